// ===== rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg: shared types, constants and helpers for the nearest palette color unit
// Holds the pixel and candidate types, the 64-entry palette ROM and the
// compare helpers for the minimum tree.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int CHAN_W   = 8;
    localparam int PAL_SIZE = 64;
    localparam int IDX_W    = $clog2(PAL_SIZE);
    localparam int SQ_W     = 2 * CHAN_W;
    // 3 * 255 * 255 = 195075 fits in 18 bits
    localparam int DIST_W   = SQ_W + 2;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
    } cand_t;

    // palette ROM, each entry as red, green, blue
    localparam pixel_t PALETTE [PAL_SIZE] = '{
        {8'd117, 8'd117, 8'd117}, {8'd39,  8'd27,  8'd143}, {8'd0,   8'd0,   8'd171},
        {8'd71,  8'd0,   8'd159}, {8'd143, 8'd0,   8'd119}, {8'd171, 8'd0,   8'd19},
        {8'd167, 8'd0,   8'd0},   {8'd127, 8'd11,  8'd0},   {8'd67,  8'd47,  8'd0},
        {8'd0,   8'd71,  8'd0},   {8'd0,   8'd81,  8'd0},   {8'd0,   8'd63,  8'd23},
        {8'd27,  8'd63,  8'd95},  {8'd0,   8'd0,   8'd0},   {8'd0,   8'd0,   8'd0},
        {8'd0,   8'd0,   8'd0},
        {8'd188, 8'd188, 8'd188}, {8'd0,   8'd115, 8'd239}, {8'd35,  8'd59,  8'd239},
        {8'd131, 8'd0,   8'd243}, {8'd191, 8'd0,   8'd191}, {8'd231, 8'd0,   8'd91},
        {8'd219, 8'd43,  8'd0},   {8'd203, 8'd79,  8'd15},  {8'd139, 8'd115, 8'd0},
        {8'd0,   8'd151, 8'd0},   {8'd0,   8'd171, 8'd0},   {8'd0,   8'd147, 8'd59},
        {8'd0,   8'd131, 8'd139}, {8'd0,   8'd0,   8'd0},   {8'd0,   8'd0,   8'd0},
        {8'd0,   8'd0,   8'd0},
        {8'd255, 8'd255, 8'd255}, {8'd63,  8'd191, 8'd255}, {8'd95,  8'd115, 8'd255},
        {8'd167, 8'd139, 8'd253}, {8'd247, 8'd123, 8'd255}, {8'd255, 8'd119, 8'd183},
        {8'd255, 8'd119, 8'd99},  {8'd255, 8'd155, 8'd59},  {8'd243, 8'd191, 8'd63},
        {8'd131, 8'd211, 8'd19},  {8'd79,  8'd223, 8'd75},  {8'd88,  8'd248, 8'd152},
        {8'd0,   8'd235, 8'd219}, {8'd117, 8'd117, 8'd117}, {8'd0,   8'd0,   8'd0},
        {8'd0,   8'd0,   8'd0},
        {8'd255, 8'd255, 8'd255}, {8'd171, 8'd231, 8'd255}, {8'd199, 8'd215, 8'd255},
        {8'd215, 8'd203, 8'd255}, {8'd255, 8'd199, 8'd255}, {8'd255, 8'd199, 8'd219},
        {8'd255, 8'd191, 8'd179}, {8'd255, 8'd219, 8'd171}, {8'd255, 8'd231, 8'd163},
        {8'd227, 8'd255, 8'd163}, {8'd171, 8'd243, 8'd191}, {8'd179, 8'd255, 8'd207},
        {8'd159, 8'd255, 8'd243}, {8'd188, 8'd188, 8'd188}, {8'd0,   8'd0,   8'd0},
        {8'd0,   8'd0,   8'd0}
    };

    // a is the lower index: keep it unless b is strictly closer
    function automatic cand_t min2(input cand_t a, input cand_t b);
        return (b.sq_dist < a.sq_dist) ? b : a;
    endfunction

    // inputs in ascending index order
    function automatic cand_t min4(input cand_t a, input cand_t b,
                                   input cand_t c, input cand_t d);
        return min2(min2(a, b), min2(c, d));
    endfunction

endpackage

// ===== rtl/npc_dist_lane.sv =====
// ----------------------------------------------------------------------------
// npc_dist_lane: squared distance from one pixel to one palette entry
// Three register stages: absolute channel differences, squares, sum.
// ----------------------------------------------------------------------------
module npc_dist_lane
(
    input  logic                       clk,
    input  logic                       en,
    input  npc_pkg::pixel_t            pixel,
    input  npc_pkg::pixel_t            entry,
    output logic [npc_pkg::DIST_W-1:0] sq_dist
);

    logic [npc_pkg::CHAN_W-1:0] dr_reg, dg_reg, db_reg;
    logic [npc_pkg::CHAN_W-1:0] dr_next, dg_next, db_next;
    logic [npc_pkg::SQ_W-1:0]   sr_reg, sg_reg, sb_reg;
    logic [npc_pkg::DIST_W-1:0] sum_reg;

    always_comb
    begin
        dr_next = (pixel.red > entry.red) ? pixel.red - entry.red : entry.red - pixel.red;
        dg_next = (pixel.green > entry.green) ? pixel.green - entry.green
                                              : entry.green - pixel.green;
        db_next = (pixel.blue > entry.blue) ? pixel.blue - entry.blue
                                            : entry.blue - pixel.blue;
    end

    // payload only, held while the pipe is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg  <= dr_next;
            dg_reg  <= dg_next;
            db_reg  <= db_next;
            sr_reg  <= npc_pkg::SQ_W'(dr_reg) * npc_pkg::SQ_W'(dr_reg);
            sg_reg  <= npc_pkg::SQ_W'(dg_reg) * npc_pkg::SQ_W'(dg_reg);
            sb_reg  <= npc_pkg::SQ_W'(db_reg) * npc_pkg::SQ_W'(db_reg);
            sum_reg <= npc_pkg::DIST_W'(sr_reg) + npc_pkg::DIST_W'(sg_reg)
                     + npc_pkg::DIST_W'(sb_reg);
        end
    end

    assign sq_dist = sum_reg;

endmodule

// ===== rtl/nearest_palette_color_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_unit: nearest palette entry for a 24-bit pixel
// Maps each pixel to the index of the closest of 64 palette colors by squared
// distance over red, green and blue; the lowest index wins a tie.
// ----------------------------------------------------------------------------
//
//  channel   dir  word                        fields (low bit up)
//  s_axis    in   24-bit pixel                blue[7:0] green[15:8] red[23:16]
//  m_axis    out  8-bit palette index         color_index[5:0], zero pad[7:6]
//
//  Throughput: one pixel per clock while m_axis_tready does not stall the pipe.
//  Pipeline: six register stages (3 lane stages for distance, 3 stages of the
//  64-to-1 minimum tree, two compare levels in each).
//  Stalls: the whole pipe advances on one enable; when the output word waits
//  and m_axis_tready is low, every stage holds and s_axis_tready drops.
//  Reset: clears the valid bits only; the data registers are not reset.
//
module nearest_palette_color_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // color_index[5:0], zeros[7:6]
);

    localparam int STAGES = 6;
    localparam int L1_N   = npc_pkg::PAL_SIZE / 4;
    localparam int L2_N   = L1_N / 4;

    logic                      en;
    logic [STAGES-1:0]         valid_reg;
    logic [STAGES-1:0]         valid_next;
    npc_pkg::pixel_t           pixel;
    logic [npc_pkg::DIST_W-1:0] lane_dist [npc_pkg::PAL_SIZE];
    npc_pkg::cand_t            lane_cand [npc_pkg::PAL_SIZE];
    npc_pkg::cand_t            l1_reg  [L1_N];
    npc_pkg::cand_t            l1_next [L1_N];
    npc_pkg::cand_t            l2_reg  [L2_N];
    npc_pkg::cand_t            l2_next [L2_N];
    npc_pkg::cand_t            best_next;
    logic [npc_pkg::IDX_W-1:0] idx_reg;

    // advance whenever the output stage is empty or being taken
    assign en            = !valid_reg[STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;

    assign pixel.blue  = s_axis_tdata[7:0];
    assign pixel.green = s_axis_tdata[15:8];
    assign pixel.red   = s_axis_tdata[23:16];

    // one distance lane per palette entry
    for (genvar i = 0; i < npc_pkg::PAL_SIZE; i++)
    begin : g_lane
        npc_dist_lane u_lane
        (
            .clk     (clk),
            .en      (en),
            .pixel   (pixel),
            .entry   (npc_pkg::PALETTE[i]),
            .sq_dist (lane_dist[i])
        );
        assign lane_cand[i].sq_dist = lane_dist[i];
        assign lane_cand[i].idx     = npc_pkg::IDX_W'(i);
    end

    // minimum tree, groups kept in index order so ties go to the lower index
    always_comb
    begin
        for (int k = 0; k < L1_N; k++)
        begin
            l1_next[k] = npc_pkg::min4(lane_cand[4*k], lane_cand[4*k+1],
                                       lane_cand[4*k+2], lane_cand[4*k+3]);
        end
        for (int k = 0; k < L2_N; k++)
        begin
            l2_next[k] = npc_pkg::min4(l1_reg[4*k], l1_reg[4*k+1],
                                       l1_reg[4*k+2], l1_reg[4*k+3]);
        end
        best_next = npc_pkg::min4(l2_reg[0], l2_reg[1], l2_reg[2], l2_reg[3]);
    end

    // valid bits shift along with the data
    assign valid_next = {valid_reg[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg  <= l1_next;
            l2_reg  <= l2_next;
            idx_reg <= best_next.idx;
        end
    end

    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = {(8 - npc_pkg::IDX_W)'(0), idx_reg};

endmodule

// ===== rtl/npc_checker.sv =====
// ----------------------------------------------------------------------------
// npc_checker: port-level checks for nearest_palette_color_unit
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module npc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // a waiting output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // a waiting input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input word changed while stalled");

    // the pipe only stops when the output word waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // index stays within the palette, pad bits are zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
        else $error("nonzero pad bits in output word");

    // reset empties the pipe
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind nearest_palette_color_unit npc_checker u_npc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
